FILE: hdl/c32cbcs_pkg.sv
// shared constants and types for the crc32c block checksum unit
// no dependencies; used by c32cbcs_crc_step and the top level

package c32cbcs_pkg;

  localparam int unsigned MAX_BLOCK_BYTES = 65536;
  // byte counter saturates at MAX_BLOCK_BYTES, so it must hold that value
  localparam int unsigned POS_W = $clog2(MAX_BLOCK_BYTES + 1);

  localparam int unsigned CRC_W   = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned OFS_W   = 16;
  localparam int unsigned FIELD_BYTES = 4;
  // compare width covers both the counter and offset + field length
  localparam int unsigned CMP_W = (POS_W > OFS_W + 1) ? POS_W : OFS_W + 1;

  localparam logic [CRC_W-1:0] CRC_POLY_REFLECTED = 32'h82F6_3B78;
  localparam logic [CRC_W-1:0] CRC_SEED_RESET     = 32'hFFFF_FFFF;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_CRC_SEED        = 2'd0,
    REG_CHECKSUM_OFFSET = 2'd1,
    REG_SKIP_ENABLE     = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

endpackage

FILE: hdl/crc32c_block_checksum_skip_field.sv
// top level of the crc32c block checksum unit with checksum field skip
// depends on c32cbcs_pkg and c32cbcs_crc_step
//
// Usage:
//   A metadata block enters on the in_ channel one byte per transaction,
//   with in_last_byte high on its final byte. The CRC starts from the
//   seed register on the first byte of each block. When skip is enabled,
//   the four bytes at checksum_offset are left out of the CRC; they are
//   always captured big-endian as the stored checksum.
//   On the last byte one result leaves on the out_ channel: the CRC
//   register, its inverse, a match flag and a too-short flag.
//   Throughput is one byte per cycle unless a last byte waits on in_stall,
//   set by the byte XOR network feeding the CRC register. out_valid rises
//   in the cycle after the last byte is accepted (the result register).
//   When the receiver stalls, the result holds in the output register and
//   non-last bytes keep flowing; only a last byte waits (in_stall high)
//   until the held result is taken.
//   Reset (rst_n low, synchronous) restores the register defaults, clears
//   the byte counter and empties the result register. Registers are
//   written through the APB-style port at byte addresses 0, 4 and 8.

module crc32c_block_checksum_skip_field (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [c32cbcs_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                                in_last_byte,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [c32cbcs_pkg::CRC_W-1:0]       out_crc_intermediate,
  output logic [c32cbcs_pkg::CRC_W-1:0]       out_crc_final,
  output logic                                out_checksum_ok,
  output logic                                out_block_too_short,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [c32cbcs_pkg::ADDR_W-1:0]      paddr,
  input  logic [c32cbcs_pkg::DATA_W-1:0]      pwdata,
  output logic [c32cbcs_pkg::DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int unsigned CRC_W = c32cbcs_pkg::CRC_W;
  localparam int unsigned POS_W = c32cbcs_pkg::POS_W;
  localparam int unsigned CMP_W = c32cbcs_pkg::CMP_W;
  localparam int unsigned OFS_W = c32cbcs_pkg::OFS_W;
  localparam int unsigned BYTE_W = c32cbcs_pkg::BYTE_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(c32cbcs_pkg::MAX_BLOCK_BYTES);

  // configuration registers
  logic [CRC_W-1:0] crc_seed_r;
  logic [OFS_W-1:0] checksum_offset_r;
  logic             skip_enable_r;

  c32cbcs_pkg::reg_idx_t reg_idx;
  logic                  cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = c32cbcs_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_seed_r        <= c32cbcs_pkg::CRC_SEED_RESET;
      checksum_offset_r <= '0;
      skip_enable_r     <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        c32cbcs_pkg::REG_CRC_SEED:        crc_seed_r        <= pwdata;
        c32cbcs_pkg::REG_CHECKSUM_OFFSET: checksum_offset_r <= pwdata[OFS_W-1:0];
        c32cbcs_pkg::REG_SKIP_ENABLE:     skip_enable_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      c32cbcs_pkg::REG_CRC_SEED:        prdata = crc_seed_r;
      c32cbcs_pkg::REG_CHECKSUM_OFFSET: prdata = {{(32-OFS_W){1'b0}}, checksum_offset_r};
      c32cbcs_pkg::REG_SKIP_ENABLE:     prdata = {31'b0, skip_enable_r};
      default:                          prdata = '0;
    endcase
  end

  // block state
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CRC_W-1:0] stored_r, stored_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [CRC_W-1:0] res_crc_r, res_crc_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic             res_short_r, res_short_nxt;

  logic             in_accept;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] crc_upd;
  logic [POS_W-1:0] pos_inc;
  logic [CMP_W-1:0] pos_cmp, pos_inc_cmp, ofs_cmp, field_end;
  logic             in_field;
  logic [CRC_W-1:0] stored_upd;
  logic             too_short;

  // only a last byte needs the result register free
  assign in_stall  = out_valid_r & out_stall & in_last_byte;
  assign in_accept = in_valid & ~in_stall;

  assign crc_base    = (pos_r == '0) ? crc_seed_r : crc_r;
  assign pos_cmp     = CMP_W'(pos_r);
  assign ofs_cmp     = CMP_W'(checksum_offset_r);
  assign field_end   = ofs_cmp + CMP_W'(c32cbcs_pkg::FIELD_BYTES);
  assign in_field    = (pos_r < POS_MAX) && (pos_cmp >= ofs_cmp) && (pos_cmp < field_end);
  assign stored_upd  = in_field ? {stored_r[CRC_W-BYTE_W-1:0], in_data_byte} : stored_r;
  assign pos_inc     = (pos_r < POS_MAX) ? pos_r + POS_W'(1) : pos_r;
  assign pos_inc_cmp = CMP_W'(pos_inc);
  assign too_short   = pos_inc_cmp < field_end;

  c32cbcs_crc_step u_crc_step (
    .crc_in  (crc_base),
    .data_in (in_data_byte),
    .hash_en (~(in_field & skip_enable_r)),
    .crc_out (crc_upd)
  );

  always_comb begin
    crc_nxt    = crc_r;
    pos_nxt    = pos_r;
    stored_nxt = stored_r;
    if (in_accept) begin
      if (in_last_byte) begin
        crc_nxt    = crc_seed_r;
        pos_nxt    = '0;
        stored_nxt = '0;
      end else begin
        crc_nxt    = crc_upd;
        pos_nxt    = pos_inc;
        stored_nxt = stored_upd;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    res_crc_nxt   = res_crc_r;
    res_ok_nxt    = res_ok_r;
    res_short_nxt = res_short_r;
    if (in_accept && in_last_byte) begin
      out_valid_nxt = 1'b1;
      res_crc_nxt   = crc_upd;
      res_ok_nxt    = ~too_short & ((~crc_upd) == stored_upd);
      res_short_nxt = too_short;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= c32cbcs_pkg::CRC_SEED_RESET;
      pos_r       <= '0;
      stored_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      pos_r       <= pos_nxt;
      stored_r    <= stored_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_crc_r   <= res_crc_nxt;
    res_ok_r    <= res_ok_nxt;
    res_short_r <= res_short_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_crc_intermediate = res_crc_r;
  assign out_crc_final        = ~res_crc_r;
  assign out_checksum_ok      = res_ok_r;
  assign out_block_too_short  = res_short_r;

endmodule

FILE: hdl/c32cbcs_crc_step.sv
// one-byte reflected crc32c update as an xor network
// depends on c32cbcs_pkg

module c32cbcs_crc_step (
  input  logic [c32cbcs_pkg::CRC_W-1:0]  crc_in,
  input  logic [c32cbcs_pkg::BYTE_W-1:0] data_in,
  input  logic                           hash_en,
  output logic [c32cbcs_pkg::CRC_W-1:0]  crc_out
);

  logic [c32cbcs_pkg::CRC_W-1:0] c;

  always_comb begin
    c = crc_in ^ {{(c32cbcs_pkg::CRC_W - c32cbcs_pkg::BYTE_W){1'b0}}, data_in};
    // eight shift-and-conditional-xor steps, flattened by synthesis
    for (int i = 0; i < c32cbcs_pkg::BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ c32cbcs_pkg::CRC_POLY_REFLECTED;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = hash_en ? c : crc_in;
  end

endmodule
